[hw/rtl/rdc_pkg.sv]
// Shared types and constants for the region dominance counter.
// Used by the front, queue, back and top-level files; depends on nothing.
package rdc_pkg;

    // Fixed field widths
    localparam int COORD_BITS  = 16;
    localparam int MID_W       = COORD_BITS + 1;
    localparam int W_BITS      = 16;
    localparam int WEIGHT_REGS = 3;
    localparam int NPAD        = WEIGHT_REGS + 1;
    localparam int PIDX_W      = $clog2(NPAD);
    localparam int WIDX_W      = $clog2(WEIGHT_REGS);
    localparam int CORNER_W    = WEIGHT_REGS;
    localparam int CFG_IDX_W   = 3;
    localparam int DIMS_W      = 3;
    localparam int COUNT_W     = 16;
    localparam int ID_W        = 32;
    localparam int OUTC_W      = 2;

    // Arithmetic widths of the corner score difference
    localparam int H_W    = COORD_BITS + 3;
    localparam int DL_W   = COORD_BITS + 2;
    localparam int RHS_W  = DL_W + W_BITS;
    localparam int PROD_W = W_BITS + 1 + H_W;
    localparam int ACC_W  = PROD_W + 2;

    localparam int MAX_DIMS_DEF = 4;
    localparam int QDEPTH       = 2;

    localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_DIMS = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_K    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_W0   = 3'd2;

    // Item kinds
    localparam logic OP_FOCAL = 1'b0;
    localparam logic OP_CAND  = 1'b1;

    // Outcome codes
    localparam logic [OUTC_W-1:0] OUT_CAND_DOM  = 2'd0;
    localparam logic [OUTC_W-1:0] OUT_FOCAL_DOM = 2'd1;
    localparam logic [OUTC_W-1:0] OUT_MIXED     = 2'd2;

    typedef logic signed [H_W-1:0] h_t;

    // One evaluation request: score differences captured at record end
    typedef struct packed {
        logic [ID_W-1:0]         id;
        logic                    last_rec;
        h_t [WEIGHT_REGS-1:0]    h;
        logic signed [DL_W-1:0]  dl;
    } eval_req_t;

    // One result item
    typedef struct packed {
        logic [ID_W-1:0]    cand_id;
        logic [OUTC_W-1:0]  outcome;
        logic [COUNT_W-1:0] count;
        logic               survives;
        logic               final_res;
    } out_res_t;

endpackage

[hw/rtl/rdc_queue.sv]
// Short request queue between the front and back parts of the counter.
// Depends on rdc_pkg for the request type and depth.
module rdc_queue (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               push_valid,
    output logic               push_ready,
    input  rdc_pkg::eval_req_t push_data,
    output logic               pop_valid,
    input  logic               pop_ready,
    output rdc_pkg::eval_req_t pop_data
);

    localparam int PTR_W = (rdc_pkg::QDEPTH > 1) ? $clog2(rdc_pkg::QDEPTH) : 1;
    localparam int CNT_W = $clog2(rdc_pkg::QDEPTH + 1);

    rdc_pkg::eval_req_t     slot_reg [rdc_pkg::QDEPTH];
    logic [PTR_W-1:0]       wr_ptr_reg;
    logic [PTR_W-1:0]       rd_ptr_reg;
    logic [CNT_W-1:0]       count_reg;
    logic                   do_push;
    logic                   do_pop;

    assign push_ready = (count_reg != CNT_W'(rdc_pkg::QDEPTH));
    assign pop_valid  = (count_reg != '0);
    assign pop_data   = slot_reg[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    // Store incoming requests
    always_ff @(posedge aclk) begin
        if (do_push) begin
            slot_reg[wr_ptr_reg] <= push_data;
        end
    end

    // Advance pointers and occupancy
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (do_push) begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(rdc_pkg::QDEPTH - 1)) ? '0
                                                                          : wr_ptr_reg + 1'b1;
            end
            if (do_pop) begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(rdc_pkg::QDEPTH - 1)) ? '0
                                                                          : rd_ptr_reg + 1'b1;
            end
            if (do_push && !do_pop) begin
                count_reg <= count_reg + 1'b1;
            end else if (do_pop && !do_push) begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

endmodule

[hw/rtl/rdc_front.sv]
// Front part: accepts coordinate items, holds focal and midpoint stores,
// and turns each finished candidate into an evaluation request. Uses rdc_pkg.
module rdc_front #(
    parameter int MAX_DIMS = rdc_pkg::MAX_DIMS_DEF
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic [rdc_pkg::DIMS_W-1:0]          eff_dims,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  logic                                in_op,
    input  logic [1:0]                          in_coord_index,
    input  logic [rdc_pkg::COORD_BITS-1:0]      in_coord_low,
    input  logic [rdc_pkg::COORD_BITS-1:0]      in_coord_high,
    input  logic [rdc_pkg::ID_W-1:0]            in_record_id,
    input  logic                                in_last_coord,
    input  logic                                in_last_record,
    output logic                                req_valid,
    input  logic                                req_ready,
    output rdc_pkg::eval_req_t                  req_data
);

    localparam int DIDX_W = (MAX_DIMS > 1) ? $clog2(MAX_DIMS) : 1;

    logic [rdc_pkg::COORD_BITS-1:0] focal_reg [MAX_DIMS];
    logic [rdc_pkg::MID_W-1:0]      mid_reg   [MAX_DIMS];
    logic                           pending_reg;
    logic [rdc_pkg::ID_W-1:0]       pend_id_reg;
    logic                           pend_last_reg;

    logic [rdc_pkg::COORD_BITS-1:0] f_pad [rdc_pkg::NPAD];
    logic [rdc_pkg::MID_W-1:0]      m_pad [rdc_pkg::NPAD];
    logic [rdc_pkg::PIDX_W-1:0]     last_idx;
    logic signed [rdc_pkg::H_W-1:0] fl2_s;
    logic signed [rdc_pkg::H_W-1:0] ml_s;
    logic                           accept;
    logic                           idx_ok;
    logic [DIDX_W-1:0]              store_idx;

    assign in_ready  = !pending_reg;
    assign accept    = in_valid && in_ready;
    assign idx_ok    = (int'(in_coord_index) < MAX_DIMS);
    assign store_idx = DIDX_W'(in_coord_index);

    // Write the focal store (reset to zero)
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < MAX_DIMS; i++) begin
                focal_reg[i] <= '0;
            end
        end else if (accept && idx_ok && in_op == rdc_pkg::OP_FOCAL) begin
            focal_reg[store_idx] <= in_coord_low;
        end
    end

    // Write the midpoint store as the sum of the bounds
    always_ff @(posedge aclk) begin
        if (accept && idx_ok && in_op == rdc_pkg::OP_CAND) begin
            mid_reg[store_idx] <= {1'b0, in_coord_low} + {1'b0, in_coord_high};
        end
    end

    // Hold a finished candidate until the queue takes its request
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pending_reg <= 1'b0;
        end else if (pending_reg) begin
            if (req_ready) begin
                pending_reg <= 1'b0;
            end
        end else if (accept && idx_ok && in_op == rdc_pkg::OP_CAND && in_last_coord) begin
            pending_reg <= 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            pend_id_reg   <= in_record_id;
            pend_last_reg <= in_last_record;
        end
    end

    // Pad the stores out to the widest weight region
    for (genvar i = 0; i < rdc_pkg::NPAD; i++) begin : g_pad
        if (i < MAX_DIMS) begin : g_use
            assign f_pad[i] = focal_reg[i];
            assign m_pad[i] = mid_reg[i];
        end else begin : g_zero
            assign f_pad[i] = '0;
            assign m_pad[i] = '0;
        end
    end

    // Score differences relative to the last dimension
    assign last_idx = rdc_pkg::PIDX_W'(eff_dims - 3'd1);
    assign fl2_s    = $signed({2'b00, f_pad[last_idx], 1'b0});
    assign ml_s     = $signed({2'b00, m_pad[last_idx]});

    always_comb begin
        req_data.id       = pend_id_reg;
        req_data.last_rec = pend_last_reg;
        for (int d = 0; d < rdc_pkg::WEIGHT_REGS; d++) begin
            req_data.h[d] = $signed({2'b00, f_pad[d], 1'b0}) - fl2_s
                            - $signed({2'b00, m_pad[d]}) + ml_s;
        end
        req_data.dl = $signed({1'b0, m_pad[last_idx]})
                      - $signed({1'b0, f_pad[last_idx], 1'b0});
    end

    assign req_valid = pending_reg;

endmodule

[hw/rtl/rdc_back.sv]
// Back part: walks every corner of the weight box with one shared
// multiply-accumulate, classifies the candidate and keeps the count. Uses rdc_pkg.
module rdc_back (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  logic [rdc_pkg::DIMS_W-1:0]            eff_dims,
    input  logic [rdc_pkg::COUNT_W-1:0]           k_limit,
    input  logic [2*rdc_pkg::W_BITS-1:0]          weights [rdc_pkg::WEIGHT_REGS],
    input  logic                                  req_valid,
    output logic                                  req_ready,
    input  rdc_pkg::eval_req_t                    req_data,
    output logic                                  res_valid,
    input  logic                                  res_ready,
    output rdc_pkg::out_res_t                     res_data
);

    typedef enum logic [1:0] {ST_IDLE, ST_EVAL, ST_DRAIN} state_t;

    state_t                            state_reg;
    rdc_pkg::eval_req_t                req_reg;
    logic [rdc_pkg::CORNER_W-1:0]      corner_reg;
    logic [rdc_pkg::WIDX_W-1:0]        dim_reg;
    logic signed [rdc_pkg::PROD_W-1:0] prod_reg;
    logic                              prod_vld_reg;
    logic                              prod_first_reg;
    logic                              prod_end_reg;
    logic                              prod_fin_reg;
    logic signed [rdc_pkg::ACC_W-1:0]  acc_reg;
    logic                              all_above_reg;
    logic                              all_atleast_reg;
    logic                              done_reg;
    logic [rdc_pkg::COUNT_W-1:0]       count_reg;
    logic                              res_valid_reg;
    rdc_pkg::out_res_t                 res_reg;

    logic [rdc_pkg::WIDX_W-1:0]        dim_last;
    logic [rdc_pkg::CORNER_W-1:0]      corner_last;
    logic [2*rdc_pkg::W_BITS-1:0]      wsel;
    logic [rdc_pkg::W_BITS-1:0]        w;
    logic signed [rdc_pkg::PROD_W-1:0] prod_next;
    logic                              step_end;
    logic                              step_fin;
    logic signed [rdc_pkg::ACC_W-1:0]  acc_base;
    logic signed [rdc_pkg::ACC_W-1:0]  acc_sum;
    logic signed [rdc_pkg::RHS_W-1:0]  rhs;
    logic                              above;
    logic                              out_free;
    logic                              res_load;
    logic [rdc_pkg::OUTC_W-1:0]        outcome;
    logic [rdc_pkg::COUNT_W-1:0]       count_inc;

    // Corner and weight-dimension bounds from the dimension count
    assign dim_last    = rdc_pkg::WIDX_W'(eff_dims - 3'd2);
    assign corner_last = rdc_pkg::CORNER_W'(((rdc_pkg::CORNER_W + 1)'(1)
                                             << (eff_dims - 3'd1)) - 1'b1);

    // Issue stage: one weight times one score difference
    assign wsel      = weights[dim_reg];
    assign w         = corner_reg[dim_reg] ? wsel[2*rdc_pkg::W_BITS-1:rdc_pkg::W_BITS]
                                           : wsel[rdc_pkg::W_BITS-1:0];
    assign prod_next = $signed({1'b0, w}) * $signed(req_reg.h[dim_reg]);
    assign step_end  = (dim_reg == dim_last);
    assign step_fin  = step_end && (corner_reg == corner_last);

    // Accumulate stage and corner compare
    assign acc_base = prod_first_reg ? '0 : acc_reg;
    assign acc_sum  = acc_base + prod_reg;
    assign rhs      = $signed({req_reg.dl, {rdc_pkg::W_BITS{1'b0}}});
    assign above    = (acc_sum > rhs);

    // Classification and count update
    assign out_free  = !res_valid_reg || res_ready;
    assign res_load  = (state_reg == ST_DRAIN) && done_reg && out_free;
    assign outcome   = all_above_reg   ? rdc_pkg::OUT_FOCAL_DOM :
                       all_atleast_reg ? rdc_pkg::OUT_CAND_DOM  : rdc_pkg::OUT_MIXED;
    assign count_inc = (outcome == rdc_pkg::OUT_CAND_DOM && count_reg != rdc_pkg::COUNT_MAX)
                       ? count_reg + 1'b1 : count_reg;

    assign req_ready = (state_reg == ST_IDLE);
    assign res_valid = res_valid_reg;
    assign res_data  = res_reg;

    // Sequencer, multiply pipeline and result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            prod_vld_reg  <= 1'b0;
            done_reg      <= 1'b0;
            count_reg     <= '0;
            res_valid_reg <= 1'b0;
        end else begin
            res_valid_reg <= res_load || (res_valid_reg && !res_ready);
            prod_vld_reg  <= (state_reg == ST_EVAL);

            unique case (state_reg)
                ST_IDLE: begin
                    if (req_valid) begin
                        req_reg         <= req_data;
                        corner_reg      <= '0;
                        dim_reg         <= '0;
                        all_above_reg   <= 1'b1;
                        all_atleast_reg <= 1'b1;
                        state_reg       <= ST_EVAL;
                    end
                end
                ST_EVAL: begin
                    prod_reg       <= prod_next;
                    prod_first_reg <= (dim_reg == '0);
                    prod_end_reg   <= step_end;
                    prod_fin_reg   <= step_fin;
                    if (step_end) begin
                        dim_reg    <= '0;
                        corner_reg <= corner_reg + 1'b1;
                    end else begin
                        dim_reg <= dim_reg + 1'b1;
                    end
                    if (step_fin) begin
                        state_reg <= ST_DRAIN;
                    end
                end
                ST_DRAIN: begin
                    if (res_load) begin
                        res_reg.cand_id   <= req_reg.id;
                        res_reg.outcome   <= outcome;
                        res_reg.count     <= count_inc;
                        res_reg.survives  <= req_reg.last_rec && (count_inc < k_limit);
                        res_reg.final_res <= req_reg.last_rec;
                        count_reg         <= req_reg.last_rec ? '0 : count_inc;
                        done_reg          <= 1'b0;
                        state_reg         <= ST_IDLE;
                    end
                end
                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase

            // Fold each finished corner into the outcome flags
            if (prod_vld_reg) begin
                acc_reg <= acc_sum;
                if (prod_end_reg) begin
                    all_above_reg   <= all_above_reg && above;
                    all_atleast_reg <= all_atleast_reg && !above;
                end
                if (prod_end_reg && prod_fin_reg) begin
                    done_reg <= 1'b1;
                end
            end
        end
    end

endmodule

[hw/rtl/region_dominance_counter.sv]
// Top level of the region dominance counter: stream ports, configuration
// registers, front, queue and back. Depends on rdc_pkg and the rdc_* modules.
//
// Send the focal point as op=0 items, then each candidate as op=1 items, one
// coordinate per item; the item flagged tlast closes a candidate and yields
// one result. Coordinate items are taken one per cycle unless a request is
// pending: the item closing a candidate stalls the input until its request
// is taken by the queue. The back evaluates each candidate on a single shared
// multiplier, one weight dimension of one corner per cycle, over D-1 weight
// dimensions for each of the 2^(D-1) corners; a two-entry request queue lets
// the next candidates load meanwhile. Configuration is accepted every cycle but
// must only change while the block is idle.
module region_dominance_counter #(
    parameter int MAX_DIMS = rdc_pkg::MAX_DIMS_DEF
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    // Input items
    input  logic                           s_tvalid,
    output logic                           s_tready,
    // coord_index[1:0], coord_low[17:2], coord_high[33:18], record_id[65:34], zero pad
    input  logic [71:0]                    s_tdata,
    input  logic                           s_tlast,   // last_coord
    // op[0], last_record[1]
    input  logic [1:0]                     s_tuser,
    // Result items
    output logic                           m_tvalid,
    input  logic                           m_tready,
    // cand_id[31:0], outcome[33:32], dominator_count[49:34], survives[50], zero pad
    output logic [55:0]                    m_tdata,
    output logic                           m_tlast,   // final_res
    // Configuration writes
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [rdc_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [31:0]                    cfg_data
);

    localparam int DIM_TOP = (MAX_DIMS < rdc_pkg::NPAD) ? MAX_DIMS : rdc_pkg::NPAD;

    logic [rdc_pkg::DIMS_W-1:0]     dims_reg;
    logic [rdc_pkg::COUNT_W-1:0]    k_limit_reg;
    logic [2*rdc_pkg::W_BITS-1:0]   weight_reg [rdc_pkg::WEIGHT_REGS];
    logic [rdc_pkg::DIMS_W-1:0]     eff_dims;

    logic                           q_push_valid;
    logic                           q_push_ready;
    rdc_pkg::eval_req_t             q_push_data;
    logic                           q_pop_valid;
    logic                           q_pop_ready;
    rdc_pkg::eval_req_t             q_pop_data;
    rdc_pkg::out_res_t              res;

    assign cfg_ready = 1'b1;

    // Register writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            dims_reg    <= 3'd4;
            k_limit_reg <= 16'd1;
            for (int i = 0; i < rdc_pkg::WEIGHT_REGS; i++) begin
                weight_reg[i] <= '0;
            end
        end else if (cfg_valid && cfg_ready) begin
            unique case (cfg_index)
                rdc_pkg::CFG_DIMS: dims_reg    <= cfg_data[rdc_pkg::DIMS_W-1:0];
                rdc_pkg::CFG_K:    k_limit_reg <= cfg_data[rdc_pkg::COUNT_W-1:0];
                default: begin
                    if (cfg_index >= rdc_pkg::CFG_W0 &&
                        int'(cfg_index) < int'(rdc_pkg::CFG_W0) + rdc_pkg::WEIGHT_REGS) begin
                        weight_reg[rdc_pkg::WIDX_W'(cfg_index - rdc_pkg::CFG_W0)] <= cfg_data;
                    end
                end
            endcase
        end
    end

    // Clamp the dimension count to what the weight region supports
    assign eff_dims = (dims_reg < 3'd2) ? 3'd2 :
                      (int'(dims_reg) > DIM_TOP) ? rdc_pkg::DIMS_W'(DIM_TOP) : dims_reg;

    rdc_front #(
        .MAX_DIMS (MAX_DIMS)
    ) u_front (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .eff_dims       (eff_dims),
        .in_valid       (s_tvalid),
        .in_ready       (s_tready),
        .in_op          (s_tuser[0]),
        .in_coord_index (s_tdata[1:0]),
        .in_coord_low   (s_tdata[17:2]),
        .in_coord_high  (s_tdata[33:18]),
        .in_record_id   (s_tdata[65:34]),
        .in_last_coord  (s_tlast),
        .in_last_record (s_tuser[1]),
        .req_valid      (q_push_valid),
        .req_ready      (q_push_ready),
        .req_data       (q_push_data)
    );

    rdc_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push_valid (q_push_valid),
        .push_ready (q_push_ready),
        .push_data  (q_push_data),
        .pop_valid  (q_pop_valid),
        .pop_ready  (q_pop_ready),
        .pop_data   (q_pop_data)
    );

    rdc_back u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .eff_dims  (eff_dims),
        .k_limit   (k_limit_reg),
        .weights   (weight_reg),
        .req_valid (q_pop_valid),
        .req_ready (q_pop_ready),
        .req_data  (q_pop_data),
        .res_valid (m_tvalid),
        .res_ready (m_tready),
        .res_data  (res)
    );

    // Pack the result
    assign m_tdata = {5'b0, res.survives, res.count, res.outcome, res.cand_id};
    assign m_tlast = res.final_res;

    // Survival is reported only on the final result
    a_surv_final: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tlast) |-> !m_tdata[50])
        else $error("survives set on a non-final result");

    // A dominating candidate always leaves a nonzero count
    a_dom_count: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tdata[33:32] == rdc_pkg::OUT_CAND_DOM) |-> (m_tdata[49:34] != '0))
        else $error("dominator result with zero count");

    // Outcome code is always a defined one
    a_outcome: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[33:32] == rdc_pkg::OUT_CAND_DOM ||
                      m_tdata[33:32] == rdc_pkg::OUT_FOCAL_DOM ||
                      m_tdata[33:32] == rdc_pkg::OUT_MIXED))
        else $error("undefined outcome code");

    // A request blocked by a full queue holds until taken, with input stalled
    a_req_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (q_push_valid && !q_push_ready) |=> (q_push_valid && $stable(q_push_data) && !s_tready))
        else $error("pending request dropped or changed");

endmodule
